@@ design/swa_pkg.sv @@
// shared constants and codes for the sweep window average / peak hold core
`default_nettype none
package swa_pkg;
  localparam int MAX_SWEEPS_DEF  = 16;
  localparam int MAX_BINS_DEF    = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int BIN_W       = 8;
  localparam int STATUS_W    = 2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVER   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADLEN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CLEAR  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_BINS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_SWEEPS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_AVG_EN     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_EN    = 2'd3;

  localparam logic [8:0] NUM_BINS_RST   = 9'd256;
  localparam logic [4:0] NUM_SWEEPS_RST = 5'd16;
endpackage
`default_nettype wire

@@ design/swa_if.sv @@
// valid/ready channel interfaces for sample beats and result beats
`default_nettype none
interface swa_in_if #(parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;
  modport source (output valid, operation, sample, last, input ready);
  modport sink   (input valid, operation, sample, last, output ready);
endinterface

interface swa_out_if #(parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF);
  logic                              valid;
  logic                              ready;
  logic [swa_pkg::BIN_W-1:0]         bin;
  logic signed [SAMPLE_BITS-1:0]     average;
  logic signed [SAMPLE_BITS-1:0]     peak_hold;
  logic signed [SAMPLE_BITS-1:0]     rolling_peak;
  logic [swa_pkg::STATUS_W-1:0]      status;
  logic                              sweep_end;
  modport source (output valid, bin, average, peak_hold, rolling_peak, status, sweep_end,
                  input ready);
  modport sink   (input valid, bin, average, peak_hold, rolling_peak, status, sweep_end,
                  output ready);
endinterface
`default_nettype wire

@@ design/sweep_window_average_peak_hold_core.sv @@
// sweep window average, all-time peak hold and rolling peak over a ring of sweeps
//
//  channel     dir  beat contents
//  sweep_in    in   operation, sample, last
//  result_out  out  bin, average, peak_hold, rolling_peak, status, sweep_end
//  cfg_*       in   cfg_we, cfg_index, cfg_data (write only)
//
// clear and overlong beats are answered straight from idle with a registered result; a sample beat
// passes through write_slot reduction, the window reads of the older sweeps and a bit-serial
// divider of SAMPLE_BITS + clog2(MAX_SWEEPS+1) steps, its pace set by the single read port of
// the sweep memory and the bit-serial divider
// a committing last sample then folds the sweep into the peak memory
// one item in flight; sweep_in is held off while the result register is full and unread
// synchronous active-high reset clears control state only; memories hold junk until written
`default_nettype none
module sweep_window_average_peak_hold_core #(
  parameter int MAX_SWEEPS  = swa_pkg::MAX_SWEEPS_DEF,
  parameter int MAX_BINS    = swa_pkg::MAX_BINS_DEF,
  parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  swa_in_if.sink                                 sweep_in,
  swa_out_if.source                              result_out,
  input  wire logic                              cfg_we,
  input  wire logic [swa_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [swa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  localparam int SW    = SAMPLE_BITS;
  localparam int SLW   = (MAX_SWEEPS > 1) ? $clog2(MAX_SWEEPS) : 1;
  localparam int CNW   = $clog2(MAX_SWEEPS + 1);
  localparam int BIW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int BCW   = $clog2(MAX_BINS + 1);
  localparam int DEPTH = MAX_SWEEPS * MAX_BINS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACW   = SW + CNW;
  localparam int DCW   = $clog2(ACW + 1);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_READ, S_DIV, S_COMMIT} state_t;

  // configuration
  logic [8:0] num_bins;
  logic [4:0] num_sweeps;
  logic       average_enable;
  logic       peak_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins       <= swa_pkg::NUM_BINS_RST;
      num_sweeps     <= swa_pkg::NUM_SWEEPS_RST;
      average_enable <= 1'b1;
      peak_enable    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swa_pkg::CFG_NUM_BINS:   num_bins       <= cfg_data;
        swa_pkg::CFG_NUM_SWEEPS: num_sweeps     <= cfg_data[4:0];
        swa_pkg::CFG_AVG_EN:     average_enable <= cfg_data[0];
        swa_pkg::CFG_PEAK_EN:    peak_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamped register values
  logic [BCW-1:0] nb_eff;
  logic [CNW-1:0] ns_eff;
  always_comb begin
    if (num_bins == '0)                         nb_eff = BCW'(1);
    else if (32'(num_bins) > 32'(MAX_BINS))     nb_eff = BCW'(MAX_BINS);
    else                                        nb_eff = BCW'(num_bins);
    if (num_sweeps == '0)                       ns_eff = CNW'(1);
    else if (32'(num_sweeps) > 32'(MAX_SWEEPS)) ns_eff = CNW'(MAX_SWEEPS);
    else                                        ns_eff = CNW'(num_sweeps);
  end

  // control and item registers
  state_t                state;
  logic [SLW-1:0]        write_slot;
  logic [CNW-1:0]        filled_count;
  logic [BCW-1:0]        bin_counter;
  logic signed [SW-1:0]  s_q;
  logic [BIW-1:0]        b_q;
  logic [SLW-1:0]        ws_q;
  logic [CNW-1:0]        filled_q;
  logic [CNW-1:0]        k_q;
  logic                  commit_q;
  logic                  badlen_q;

  // window read loop
  logic [SLW-1:0]        rd_slot;
  logic [CNW-1:0]        rem_cnt;
  logic                  pend;
  logic signed [ACW-1:0] sum;
  logic signed [SW-1:0]  mx;

  // divider
  logic [ACW-1:0]        dv_a;
  logic [CNW-1:0]        dv_r;
  logic [DCW-1:0]        dv_cnt;
  logic                  neg;

  // commit sweep
  logic [BCW-1:0]        cj;
  logic                  cpend;
  logic [BIW-1:0]        cjd;

  // result register
  logic                  out_valid;

  // memories
  logic signed [SW-1:0]  sweep_mem [DEPTH];
  logic signed [SW-1:0]  peak_mem  [MAX_BINS];
  logic signed [SW-1:0]  sweep_rd;
  logic signed [SW-1:0]  peak_rd;
  logic [AW-1:0]         sw_raddr;
  logic [AW-1:0]         sw_waddr;
  logic                  sw_we;
  logic [BIW-1:0]        pk_raddr;
  logic                  pk_we;
  logic signed [SW-1:0]  pk_wdata;

  // item decode at the input
  logic                  in_ready;
  logic                  in_fire;
  logic                  res_load;
  logic [CNW-1:0]        filled_now;
  logic [CNW-1:0]        k_now;
  logic                  ws_big;
  logic [SLW-1:0]        rd_dec;
  logic [CNW+1-1:0]      dv_trial;
  logic                  dv_ge;
  logic [SW-1:0]         quo;
  logic signed [SW-1:0]  avg_res;
  logic signed [SW-1:0]  pk_res;

  assign in_ready        = (state == S_IDLE) && (!out_valid || result_out.ready);
  assign sweep_in.ready  = in_ready;
  assign in_fire         = sweep_in.valid && in_ready;
  assign result_out.valid = out_valid;

  always_comb begin
    filled_now = (filled_count > ns_eff) ? ns_eff : filled_count;
    k_now      = (filled_now > ns_eff - CNW'(1)) ? ns_eff - CNW'(1) : filled_now;
    ws_big     = CNW'(ws_q) >= ns_eff;
    rd_dec     = (rd_slot == '0) ? SLW'(ns_eff - CNW'(1)) : rd_slot - SLW'(1);
    dv_trial   = {dv_r, dv_a[ACW-1]};
    dv_ge      = dv_trial >= {1'b0, k_q + CNW'(1)};
    quo        = dv_a[SW-1:0];
    avg_res    = neg ? -$signed(quo) : $signed(quo);
    pk_res     = (filled_q != '0 && peak_rd > s_q) ? peak_rd : s_q;
    // a new result lands in the register this cycle
    res_load   = (in_fire && (sweep_in.operation == swa_pkg::OP_CLEAR ||
                              bin_counter >= nb_eff)) ||
                 (state == S_DIV && dv_cnt == '0);
  end

  // memory address selection
  always_comb begin
    sw_we    = (state == S_PREP) && !ws_big;
    sw_waddr = AW'(int'(ws_q) * MAX_BINS + int'(b_q));
    if (state == S_COMMIT)
      sw_raddr = AW'(int'(ws_q) * MAX_BINS + int'(cj));
    else
      sw_raddr = AW'(int'(rd_dec) * MAX_BINS + int'(b_q));
    pk_raddr = (state == S_COMMIT) ? BIW'(cj) : b_q;
    pk_we    = (state == S_COMMIT) && cpend;
    // first commit after a clear copies the sweep
    pk_wdata = (filled_q == '0 || sweep_rd > peak_rd) ? sweep_rd : peak_rd;
  end

  always_ff @(posedge clk) begin
    if (sw_we) sweep_mem[sw_waddr] <= s_q;
    sweep_rd <= sweep_mem[sw_raddr];
  end

  always_ff @(posedge clk) begin
    if (pk_we) peak_mem[cjd] <= pk_wdata;
    peak_rd <= peak_mem[pk_raddr];
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      write_slot   <= '0;
      filled_count <= '0;
      bin_counter  <= '0;
      out_valid    <= 1'b0;
      pend         <= 1'b0;
      cpend        <= 1'b0;
    end else begin
      if (out_valid && result_out.ready && !res_load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            result_out.bin          <= '0;
            result_out.average      <= '0;
            result_out.peak_hold    <= '0;
            result_out.rolling_peak <= '0;
            if (sweep_in.operation == swa_pkg::OP_CLEAR) begin
              write_slot           <= '0;
              filled_count         <= '0;
              bin_counter          <= '0;
              result_out.status    <= swa_pkg::ST_CLEAR;
              result_out.sweep_end <= 1'b0;
              out_valid            <= 1'b1;
            end else if (bin_counter >= nb_eff) begin
              // overlong sample dropped; a last one closes the bad sweep
              if (sweep_in.last) begin
                result_out.status    <= swa_pkg::ST_BADLEN;
                result_out.sweep_end <= 1'b1;
                bin_counter          <= '0;
              end else begin
                result_out.status    <= swa_pkg::ST_OVER;
                result_out.sweep_end <= 1'b0;
              end
              out_valid <= 1'b1;
            end else begin
              s_q      <= sweep_in.sample;
              b_q      <= BIW'(bin_counter);
              ws_q     <= write_slot;
              filled_q <= filled_now;
              k_q      <= k_now;
              commit_q <= sweep_in.last && (bin_counter + BCW'(1) == nb_eff);
              badlen_q <= sweep_in.last && (bin_counter + BCW'(1) != nb_eff);
              bin_counter <= sweep_in.last ? '0 : bin_counter + BCW'(1);
              state    <= S_PREP;
            end
          end
        end
        S_PREP: begin
          // reduce the slot into a possibly shrunk ring, then store the sample
          if (ws_big) begin
            ws_q <= SLW'(CNW'(ws_q) - ns_eff);
          end else begin
            if (commit_q) begin
              write_slot   <= (CNW'(ws_q) + CNW'(1) == ns_eff) ? '0 : ws_q + SLW'(1);
              filled_count <= (filled_q < ns_eff) ? filled_q + CNW'(1) : ns_eff;
            end
            rd_slot <= ws_q;
            rem_cnt <= k_q;
            pend    <= 1'b0;
            sum     <= {{(ACW-SW){s_q[SW-1]}}, s_q};
            mx      <= s_q;
            state   <= S_READ;
          end
        end
        S_READ: begin
          // one older sweep read per cycle, folded in the cycle after its read
          pend <= rem_cnt != '0;
          if (rem_cnt != '0) begin
            rd_slot <= rd_dec;
            rem_cnt <= rem_cnt - CNW'(1);
          end
          if (pend) begin
            sum <= sum + {{(ACW-SW){sweep_rd[SW-1]}}, sweep_rd};
            if (sweep_rd > mx) mx <= sweep_rd;
          end
          if (rem_cnt == '0 && !pend) begin
            neg    <= sum[ACW-1];
            dv_a   <= sum[ACW-1] ? ACW'(-sum) : ACW'(sum);
            dv_r   <= '0;
            dv_cnt <= DCW'(ACW);
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_cnt != '0) begin
            dv_r   <= dv_ge ? CNW'(dv_trial - {1'b0, k_q + CNW'(1)}) : CNW'(dv_trial);
            dv_a   <= {dv_a[ACW-2:0], dv_ge};
            dv_cnt <= dv_cnt - DCW'(1);
          end else begin
            result_out.bin          <= swa_pkg::BIN_W'(b_q);
            result_out.average      <= average_enable ? avg_res : '0;
            result_out.peak_hold    <= peak_enable ? pk_res : '0;
            result_out.rolling_peak <= peak_enable ? mx : '0;
            result_out.status       <= badlen_q ? swa_pkg::ST_BADLEN : swa_pkg::ST_OK;
            result_out.sweep_end    <= commit_q || badlen_q;
            out_valid               <= 1'b1;
            cj    <= '0;
            cpend <= 1'b0;
            state <= commit_q ? S_COMMIT : S_IDLE;
          end
        end
        S_COMMIT: begin
          // fold the finished sweep into the peak memory, one bin a cycle
          cpend <= cj != nb_eff;
          if (cj != nb_eff) begin
            cjd <= BIW'(cj);
            cj  <= cj + BCW'(1);
          end
          if (cj == nb_eff && !cpend) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    in_fire && sweep_in.operation == swa_pkg::OP_CLEAR |=> filled_count == '0 && write_slot == '0)
    else $error("clear did not empty the window");
  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    32'(filled_count) <= 32'(MAX_SWEEPS))
    else $error("filled count beyond ring size");
  a_busy_holds_off: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !sweep_in.ready)
    else $error("input taken while an item is in flight");
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && dv_cnt == '0 |=> out_valid)
    else $error("sample result not registered");
endmodule
`default_nettype wire
